@@ rtl/core/plrc_pkg.sv @@
// ----------------------------------------------------------------------------
// plrc_pkg
// Shared types, constants and key/value helpers for the route cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plrc_pkg;

    localparam int ENTRIES_DEF = 48;

    localparam int KEY_W      = 64;
    localparam int VLO_W      = 64;
    localparam int VHI_W      = 24;
    localparam int STAMP_W    = 32;
    localparam int KIND_W     = 2;
    localparam int KEY_BYTES  = KEY_W / 8;
    localparam int VAL_BYTES  = (VLO_W + VHI_W) / 8;

    localparam int S_TDATA_W  = 192;
    localparam int S_TUSER_W  = KIND_W;
    localparam int M_TDATA_W  = KEY_W + VHI_W + VLO_W;
    localparam int M_TUSER_W  = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_FAIL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_PENDING  = 2'd1,
        SLOT_RESOLVED = 2'd2
    } slot_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    // Search record that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic               match_hit;
        logic               match_resolved;
        logic [VLO_W-1:0]   match_vlo;
        logic [VHI_W-1:0]   match_vhi;
        logic               free_hit;
        logic               best_hit;
        logic [STAMP_W-1:0] best_stamp;
    } scan_rec_t;

    // Slot update broadcast to every cell; only the addressed cell takes it.
    typedef struct packed {
        logic               en;
        slot_status_t       status;
        logic               key_we;
        logic [KEY_W-1:0]   key;
        logic               val_we;
        logic [VLO_W-1:0]   vlo;
        logic [VHI_W-1:0]   vhi;
        logic               stamp_we;
        logic [STAMP_W-1:0] stamp;
    } wr_cmd_t;

    // Clears bytes from the first NUL on, then drops trailing spaces and tabs.
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
        logic [KEY_BYTES-1:0] nz_prefix;
        logic [KEY_BYTES:0]   keep;
        logic [7:0]           c;
        logic [KEY_W-1:0]     res;
        nz_prefix[0] = (raw[7:0] != 8'h00);
        for (int j = 1; j < KEY_BYTES; j++)
        begin
            nz_prefix[j] = nz_prefix[j-1] && (raw[8*j +: 8] != 8'h00);
        end
        keep[KEY_BYTES] = 1'b0;
        for (int j = KEY_BYTES - 1; j >= 0; j--)
        begin
            c = raw[8*j +: 8];
            keep[j] = nz_prefix[j] && ((c != CH_SPACE && c != CH_TAB) || keep[j+1]);
        end
        for (int j = 0; j < KEY_BYTES; j++)
        begin
            res[8*j +: 8] = keep[j] ? raw[8*j +: 8] : 8'h00;
        end
        return res;
    endfunction

    // Clears every byte of the 11-byte value from its first NUL on.
    function automatic logic [VHI_W+VLO_W-1:0] normalize_value(
        input logic [VHI_W+VLO_W-1:0] raw
    );
        logic [VAL_BYTES-1:0]     nz_prefix;
        logic [VHI_W+VLO_W-1:0]   res;
        nz_prefix[0] = (raw[7:0] != 8'h00);
        for (int j = 1; j < VAL_BYTES; j++)
        begin
            nz_prefix[j] = nz_prefix[j-1] && (raw[8*j +: 8] != 8'h00);
        end
        for (int j = 0; j < VAL_BYTES; j++)
        begin
            res[8*j +: 8] = nz_prefix[j] ? raw[8*j +: 8] : 8'h00;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/plrc_cell.sv @@
// ----------------------------------------------------------------------------
// plrc_cell
// One cache slot: holds status, key, value and stamp, and updates the
// search record that passes through it on its way to the next slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plrc_cell #(
    parameter int IDX_W    = $clog2(plrc_pkg::ENTRIES_DEF),
    parameter int CELL_IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plrc_pkg::scan_rec_t   scan_in,
    input  logic [IDX_W-1:0]      match_idx_in,
    input  logic [IDX_W-1:0]      free_idx_in,
    input  logic [IDX_W-1:0]      best_idx_in,
    output plrc_pkg::scan_rec_t   scan_out,
    output logic [IDX_W-1:0]      match_idx_out,
    output logic [IDX_W-1:0]      free_idx_out,
    output logic [IDX_W-1:0]      best_idx_out,
    input  plrc_pkg::wr_cmd_t     wr,
    input  logic [IDX_W-1:0]      wr_idx
);

    import plrc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    slot_status_t       status_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VLO_W-1:0]   vlo_reg;
    logic [VHI_W-1:0]   vhi_reg;
    logic [STAMP_W-1:0] stamp_reg;

    scan_rec_t          rec_reg, rec_next;
    logic               valid_reg;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;

    logic               wr_hit;

    assign wr_hit = wr.en && (wr_idx == MY_IDX);

    always_comb
    begin
        rec_next       = scan_in;
        match_idx_next = match_idx_in;
        free_idx_next  = free_idx_in;
        best_idx_next  = best_idx_in;
        if (!scan_in.match_hit && status_reg != SLOT_FREE && key_reg == scan_in.key)
        begin
            rec_next.match_hit      = 1'b1;
            rec_next.match_resolved = (status_reg == SLOT_RESOLVED);
            rec_next.match_vlo      = vlo_reg;
            rec_next.match_vhi      = vhi_reg;
            match_idx_next          = MY_IDX;
        end
        if (!scan_in.free_hit && status_reg == SLOT_FREE)
        begin
            rec_next.free_hit = 1'b1;
            free_idx_next     = MY_IDX;
        end
        // Strict compare keeps the lower slot on a tie.
        if (status_reg == SLOT_RESOLVED &&
            (!scan_in.best_hit || stamp_reg < scan_in.best_stamp))
        begin
            rec_next.best_hit   = 1'b1;
            rec_next.best_stamp = stamp_reg;
            best_idx_next       = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= SLOT_FREE;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= scan_in.valid;
            if (wr_hit)
            begin
                status_reg <= wr.status;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg       <= rec_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        best_idx_reg  <= best_idx_next;
        if (wr_hit && wr.key_we)
        begin
            key_reg <= wr.key;
        end
        if (wr_hit && wr.val_we)
        begin
            vlo_reg <= wr.vlo;
            vhi_reg <= wr.vhi;
        end
        if (wr_hit && wr.stamp_we)
        begin
            stamp_reg <= wr.stamp;
        end
    end

    // The valid flag comes from the reset register; the rest is plain data.
    always_comb
    begin
        scan_out       = rec_reg;
        scan_out.valid = valid_reg;
    end

    assign match_idx_out = match_idx_reg;
    assign free_idx_out  = free_idx_reg;
    assign best_idx_out  = best_idx_reg;

endmodule

@@ rtl/core/plrc_chain.sv @@
// ----------------------------------------------------------------------------
// plrc_chain
// Row of slot cells; the search record moves one cell per cycle from slot 0
// to the last slot, and updates reach the addressed cell directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plrc_chain #(
    parameter int ENTRIES = plrc_pkg::ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plrc_pkg::scan_rec_t   scan_in,
    output plrc_pkg::scan_rec_t   scan_out,
    output logic [IDX_W-1:0]      match_idx,
    output logic [IDX_W-1:0]      free_idx,
    output logic [IDX_W-1:0]      best_idx,
    input  plrc_pkg::wr_cmd_t     wr,
    input  logic [IDX_W-1:0]      wr_idx
);

    import plrc_pkg::*;

    scan_rec_t        rec   [0:ENTRIES];
    logic [IDX_W-1:0] m_idx [0:ENTRIES];
    logic [IDX_W-1:0] f_idx [0:ENTRIES];
    logic [IDX_W-1:0] b_idx [0:ENTRIES];

    assign rec[0]   = scan_in;
    assign m_idx[0] = '0;
    assign f_idx[0] = '0;
    assign b_idx[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        plrc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .scan_in       (rec[i]),
            .match_idx_in  (m_idx[i]),
            .free_idx_in   (f_idx[i]),
            .best_idx_in   (b_idx[i]),
            .scan_out      (rec[i+1]),
            .match_idx_out (m_idx[i+1]),
            .free_idx_out  (f_idx[i+1]),
            .best_idx_out  (b_idx[i+1]),
            .wr            (wr),
            .wr_idx        (wr_idx)
        );
    end

    assign scan_out  = rec[ENTRIES];
    assign match_idx = m_idx[ENTRIES];
    assign free_idx  = f_idx[ENTRIES];
    assign best_idx  = b_idx[ENTRIES];

endmodule

@@ rtl/core/pinned_lru_route_cache_core.sv @@
// ----------------------------------------------------------------------------
// pinned_lru_route_cache_core
// Flow: a beat is registered, then searched along the row of slot cells,
// and its result is registered for output (disabled or empty-key lookups
// and unused kinds skip the search). A new beat is taken only in the idle
// state, once the last result has been registered for output.
// Reset: all slots free and enable set; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pinned_lru_route_cache_core #(
    parameter int ENTRIES = plrc_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // cfg_wr_data: enable
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: callsign, route_low, route_high, now_ms, queue_has_room, zero pad
    input  logic [plrc_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: kind
    input  logic [plrc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: found_route_low, found_route_high, fetch_callsign
    output logic [plrc_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: route_found, fetch_issued
    output logic [plrc_pkg::M_TUSER_W-1:0] m_tuser
);

    import plrc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    ctrl_state_t        state_reg, state_next;
    logic               enable_reg;

    kind_t              kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VLO_W-1:0]   vlo_reg;
    logic [VHI_W-1:0]   vhi_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               room_reg;
    logic               skip_reg;

    scan_rec_t          res_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic               accept, launch, capture, fire, skip_cond;
    scan_rec_t          chain_in, chain_out;
    logic [IDX_W-1:0]   chain_match_idx, chain_free_idx, chain_best_idx;
    wr_cmd_t            wr_cmd;
    logic [IDX_W-1:0]   wr_idx;

    logic               res_found, res_fetch;
    logic [VLO_W-1:0]   res_vlo;
    logic [VHI_W-1:0]   res_vhi;
    logic [KEY_W-1:0]   res_fkey;
    logic               victim_ok;
    logic [IDX_W-1:0]   victim_idx;
    logic [VHI_W+VLO_W-1:0] val_norm;

    assign skip_cond = (kind_reg != KIND_LOOKUP && kind_reg != KIND_STORE &&
                        kind_reg != KIND_FAIL) ||
                       (kind_reg == KIND_LOOKUP && (!enable_reg || key_reg == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        launch     = 1'b0;
        capture    = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    accept     = 1'b1;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                if (skip_cond)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    launch     = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_out.valid)
                begin
                    capture    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign val_norm = normalize_value(s_tdata[151:64]);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(s_tuser);
            key_reg   <= normalize_key(s_tdata[63:0]);
            vlo_reg   <= val_norm[VLO_W-1:0];
            vhi_reg   <= val_norm[VHI_W+VLO_W-1:VLO_W];
            stamp_reg <= s_tdata[183:152];
            room_reg  <= s_tdata[184];
        end
        if (state_reg == ST_LAUNCH)
        begin
            skip_reg <= skip_cond;
        end
        if (capture)
        begin
            res_reg       <= chain_out;
            match_idx_reg <= chain_match_idx;
            free_idx_reg  <= chain_free_idx;
            best_idx_reg  <= chain_best_idx;
        end
        if (fire)
        begin
            m_tdata_reg <= {res_fkey, res_vhi, res_vlo};
            m_tuser_reg <= {res_fetch, res_found};
        end
    end

    always_comb
    begin
        chain_in       = '0;
        chain_in.valid = launch;
        chain_in.key   = key_reg;
    end

    plrc_chain #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_in   (chain_in),
        .scan_out  (chain_out),
        .match_idx (chain_match_idx),
        .free_idx  (chain_free_idx),
        .best_idx  (chain_best_idx),
        .wr        (wr_cmd),
        .wr_idx    (wr_idx)
    );

    // Victim choice: the lowest free slot, else the least recently used
    // resolved slot. Pending slots never qualify.
    assign victim_ok  = res_reg.free_hit || res_reg.best_hit;
    assign victim_idx = res_reg.free_hit ? free_idx_reg : best_idx_reg;

    always_comb
    begin
        wr_cmd       = '0;
        wr_cmd.key   = key_reg;
        wr_cmd.stamp = stamp_reg;
        wr_idx       = match_idx_reg;
        res_found    = 1'b0;
        res_fetch    = 1'b0;
        res_vlo      = '0;
        res_vhi      = '0;
        res_fkey     = '0;
        if (!skip_reg)
        begin
            unique case (kind_reg)
                KIND_LOOKUP:
                begin
                    if (res_reg.match_hit)
                    begin
                        if (res_reg.match_resolved)
                        begin
                            wr_cmd.en       = 1'b1;
                            wr_cmd.status   = SLOT_RESOLVED;
                            wr_cmd.stamp_we = 1'b1;
                            res_found       = 1'b1;
                            res_vlo         = res_reg.match_vlo;
                            res_vhi         = res_reg.match_vhi;
                        end
                    end
                    else if (victim_ok)
                    begin
                        wr_idx    = victim_idx;
                        wr_cmd.en = 1'b1;
                        if (room_reg)
                        begin
                            wr_cmd.status   = SLOT_PENDING;
                            wr_cmd.key_we   = 1'b1;
                            wr_cmd.val_we   = 1'b1;
                            wr_cmd.stamp_we = 1'b1;
                            res_fetch       = 1'b1;
                            res_fkey        = key_reg;
                        end
                        else
                        begin
                            // No room for the request: the claimed slot ends up free.
                            wr_cmd.status = SLOT_FREE;
                        end
                    end
                end
                KIND_STORE:
                begin
                    wr_cmd.vlo = vlo_reg;
                    wr_cmd.vhi = vhi_reg;
                    if (res_reg.match_hit)
                    begin
                        wr_cmd.en       = 1'b1;
                        wr_cmd.status   = SLOT_RESOLVED;
                        wr_cmd.val_we   = 1'b1;
                        wr_cmd.stamp_we = 1'b1;
                    end
                    else if (victim_ok)
                    begin
                        wr_idx          = victim_idx;
                        wr_cmd.en       = 1'b1;
                        wr_cmd.status   = SLOT_RESOLVED;
                        wr_cmd.key_we   = 1'b1;
                        wr_cmd.val_we   = 1'b1;
                        wr_cmd.stamp_we = 1'b1;
                    end
                end
                KIND_FAIL:
                begin
                    if (res_reg.match_hit && !res_reg.match_resolved)
                    begin
                        wr_cmd.en     = 1'b1;
                        wr_cmd.status = SLOT_FREE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        wr_cmd.en = wr_cmd.en && fire;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_scan_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> state_reg == ST_SCAN)
        else $error("search record left the chain outside the scan state");

    a_scan_transit: assert property (@(posedge clk) disable iff (!rst_n)
        launch |-> ##ENTRIES chain_out.valid)
        else $error("search record did not cross the chain in ENTRIES cycles");

    a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_cmd.en |-> (state_reg == ST_FINISH && !skip_reg))
        else $error("slot update issued without a completed scan");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> $onehot0(m_tuser_reg))
        else $error("a result reports both a hit and a fetch");
`endif

endmodule
